// ===== sv/dram_frfcfs_write_drain_scheduler_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the FR-FCFS write-drain scheduler
// Property wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DRAM_FRFCFS_WRITE_DRAIN_SCHEDULER_TOP_ASSERT_SVH
`define DRAM_FRFCFS_WRITE_DRAIN_SCHEDULER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define DFWS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// The consequent must hold in the cycle after the antecedent.
`define DFWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define DFWS_ASSERT_SAME(label, clk, rst, ante, cons)
`define DFWS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== sv/dfws_pkg.sv =====
// ----------------------------------------------------------------------------
// FR-FCFS write-drain scheduler package
// Field widths, codes, reset values and shared types of the scheduler.
// ----------------------------------------------------------------------------
package dfws_pkg;

   // Field widths.
   localparam int OP_W    = 2;
   localparam int LEN_W   = 7;
   localparam int CMD_W   = 2;
   localparam int RANK_W  = 1;
   localparam int BANK_W  = 3;
   localparam int MASK_W  = 16;
   localparam int KIND_W  = 2;
   localparam int POS_W   = 6;
   localparam int WAIT_W  = 4;
   localparam int CNT_W   = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // Item operation codes.
   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_ENTRY = 2'd1;
   localparam logic [OP_W-1:0] OP_END   = 2'd2;

   // DRAM command codes.
   localparam logic [CMD_W-1:0] CMD_COLUMN    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ACTIVATE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PRECHARGE = 2'd2;

   // Issue kinds reported on the result channel.
   localparam logic [KIND_W-1:0] KIND_NONE      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REQUEST   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PRECHARGE = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_WM     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_WM      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAIT_LIMIT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE_CHAN = 2'd3;

   // Configuration reset values.
   localparam logic [LEN_W-1:0]  HIGH_WM_RESET     = 7'd40;
   localparam logic [LEN_W-1:0]  LOW_WM_RESET      = 7'd20;
   localparam logic [WAIT_W-1:0] WAIT_LIMIT_RESET  = 4'd6;
   localparam logic              SINGLE_CHAN_RESET = 1'b1;

   // Saturation points.
   localparam logic [POS_W-1:0]  POS_MAX  = '1;
   localparam logic [WAIT_W-1:0] WAIT_MAX = '1;
   localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

   // Hardware limits of the recent-access mask.
   localparam int MASK_RANKS = 2;
   localparam int MASK_BANKS = 8;

   // Running choice of the current scan.
   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [CMD_W-1:0]  cmd;
      logic [RANK_W-1:0] rank;
      logic [BANK_W-1:0] bank;
   } choice_type;

   // One result item.
   typedef struct packed {
      logic [KIND_W-1:0] issued_kind;
      logic              from_write_queue;
      logic [POS_W-1:0]  chosen_entry;
      logic [CMD_W-1:0]  chosen_cmd;
      logic [RANK_W-1:0] target_rank;
      logic [BANK_W-1:0] target_bank;
      logic              in_write_drain;
      logic [CNT_W-1:0]  row_hit_count;
      logic [CNT_W-1:0]  precharge_count;
      logic [CNT_W-1:0]  read_while_wait_count;
   } result_type;

   // Saturating increment of a statistics counter.
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] value);
      return (value == CNT_MAX) ? value : value + CNT_W'(1);
   endfunction

endpackage

// ===== sv/dfws_if.sv =====
// ----------------------------------------------------------------------------
// FR-FCFS write-drain scheduler channels
// Valid/ready channels for scheduler items, results and register writes.
// ----------------------------------------------------------------------------

// Input item channel.
interface dfws_req_if;
   logic                            valid;
   logic                            ready;
   logic [dfws_pkg::OP_W-1:0]       op;
   logic [dfws_pkg::LEN_W-1:0]      read_queue_len;
   logic [dfws_pkg::LEN_W-1:0]      write_queue_len;
   logic                            entry_is_write;
   logic                            entry_issuable;
   logic [dfws_pkg::CMD_W-1:0]      entry_next_cmd;
   logic [dfws_pkg::RANK_W-1:0]     entry_rank;
   logic [dfws_pkg::BANK_W-1:0]     entry_bank;
   logic [dfws_pkg::MASK_W-1:0]     precharge_allowed;

   modport source (output valid, op, read_queue_len, write_queue_len, entry_is_write,
                   entry_issuable, entry_next_cmd, entry_rank, entry_bank,
                   precharge_allowed, input ready);
   modport sink   (input valid, op, read_queue_len, write_queue_len, entry_is_write,
                   entry_issuable, entry_next_cmd, entry_rank, entry_bank,
                   precharge_allowed, output ready);
endinterface

// Result item channel.
interface dfws_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [dfws_pkg::KIND_W-1:0]     issued_kind;
   logic                            from_write_queue;
   logic [dfws_pkg::POS_W-1:0]      chosen_entry;
   logic [dfws_pkg::CMD_W-1:0]      chosen_cmd;
   logic [dfws_pkg::RANK_W-1:0]     target_rank;
   logic [dfws_pkg::BANK_W-1:0]     target_bank;
   logic                            in_write_drain;
   logic [dfws_pkg::CNT_W-1:0]      row_hit_count;
   logic [dfws_pkg::CNT_W-1:0]      precharge_count;
   logic [dfws_pkg::CNT_W-1:0]      read_while_wait_count;

   modport source (output valid, issued_kind, from_write_queue, chosen_entry, chosen_cmd,
                   target_rank, target_bank, in_write_drain, row_hit_count,
                   precharge_count, read_while_wait_count, input ready);
   modport sink   (input valid, issued_kind, from_write_queue, chosen_entry, chosen_cmd,
                   target_rank, target_bank, in_write_drain, row_hit_count,
                   precharge_count, read_while_wait_count, output ready);
endinterface

// Register write channel.
interface dfws_csr_if;
   logic                                valid;
   logic                                ready;
   logic [dfws_pkg::CSR_IDX_W-1:0]      index;
   logic [dfws_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/dram_frfcfs_write_drain_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// FR-FCFS DRAM command scheduler with write drain
// Picks one command per controller cycle for one DRAM channel. A controller
// cycle arrives as a start item (queue lengths, which set the write-drain
// mode), the entries of the served queue in arrival order, and an end item
// (the precharge-allowed mask). The first issuable column access wins,
// otherwise the oldest issuable entry; with nothing chosen outside write
// drain, one recently column-accessed bank whose precharge is allowed is
// closed. Items are accepted back to back while the output register is free
// or being emptied; the result of an end item appears in the next cycle,
// from the output register. Register writes take effect at once and are
// always accepted.
// ----------------------------------------------------------------------------
`include "dram_frfcfs_write_drain_scheduler_top_assert.svh"

module dram_frfcfs_write_drain_scheduler_top #(
   parameter int RANK_COUNT = 2,
   parameter int BANK_COUNT = 8
) (
   input  logic              clock,
   input  logic              reset,
   dfws_req_if.sink          req_ch,
   dfws_rsp_if.source        rsp_ch,
   dfws_csr_if.sink          csr_ch
);

   // Ranks and banks that the recent-access mask can hold.
   localparam int RankUsed = (RANK_COUNT < dfws_pkg::MASK_RANKS) ?
                             RANK_COUNT : dfws_pkg::MASK_RANKS;
   localparam int BankUsed = (BANK_COUNT < dfws_pkg::MASK_BANKS) ?
                             BANK_COUNT : dfws_pkg::MASK_BANKS;

   function automatic logic [dfws_pkg::MASK_W-1:0] used_mask(input int ranks,
                                                             input int banks);
      logic [dfws_pkg::MASK_W-1:0] mask;
      logic [3:0]                  bit_idx;
      mask = '0;
      for (int i = 0; i < dfws_pkg::MASK_W; i++) begin
         bit_idx = 4'(i);
         mask[i] = (int'(bit_idx[3]) < ranks) && (int'(bit_idx[2:0]) < banks);
      end
      return mask;
   endfunction

   localparam logic [dfws_pkg::MASK_W-1:0] RecentMask = used_mask(RankUsed, BankUsed);

   // Configuration registers.
   logic [dfws_pkg::LEN_W-1:0]   high_wm_ff;
   logic [dfws_pkg::LEN_W-1:0]   low_wm_ff;
   logic [dfws_pkg::WAIT_W-1:0]  wait_limit_ff;
   logic                         single_chan_ff;

   // Scheduler state.
   logic                         drain_mode_ff, drain_mode_in;
   logic [dfws_pkg::WAIT_W-1:0]  write_wait_ff, write_wait_in;
   logic [dfws_pkg::MASK_W-1:0]  recent_ff, recent_in;
   logic [dfws_pkg::POS_W-1:0]   entry_count_ff, entry_count_in;
   logic                         have_choice_ff, have_choice_in;
   logic                         have_hit_ff, have_hit_in;
   dfws_pkg::choice_type         choice_ff, choice_in;
   logic [dfws_pkg::CNT_W-1:0]   hit_count_ff, hit_count_in;
   logic [dfws_pkg::CNT_W-1:0]   pre_count_ff, pre_count_in;
   logic [dfws_pkg::CNT_W-1:0]   read_wait_count_ff, read_wait_count_in;

   // Output register.
   logic                         rsp_valid_ff;
   dfws_pkg::result_type         result_ff, result_in;

   logic                         req_accept;
   logic                         end_accept;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign end_accept   = req_accept && (req_ch.op == dfws_pkg::OP_END);
   assign csr_ch.ready = 1'b1;

   // Per-item state update and result formation.
   always_comb begin
      logic                         drain_v;
      logic [dfws_pkg::WAIT_W-1:0]  wait_v;
      logic                         found_v;
      logic [3:0]                   found_idx_v;
      logic [3:0]                   choice_idx_v;
      logic                         in_range_v;

      drain_mode_in      = drain_mode_ff;
      write_wait_in      = write_wait_ff;
      recent_in          = recent_ff;
      entry_count_in     = entry_count_ff;
      have_choice_in     = have_choice_ff;
      have_hit_in        = have_hit_ff;
      choice_in          = choice_ff;
      hit_count_in       = hit_count_ff;
      pre_count_in       = pre_count_ff;
      read_wait_count_in = read_wait_count_ff;
      result_in          = '0;
      drain_v            = 1'b0;
      wait_v             = write_wait_ff;
      found_v            = 1'b0;
      found_idx_v        = '0;
      choice_idx_v       = {choice_ff.rank, choice_ff.bank};
      in_range_v         = (int'(choice_ff.rank) < RankUsed) &&
                           (int'(choice_ff.bank) < BankUsed);

      if (req_accept) begin
         case (req_ch.op)
            dfws_pkg::OP_START: begin
               // Decide the drain mode for this controller cycle.
               drain_v = drain_mode_ff && (req_ch.write_queue_len > low_wm_ff);
               if (req_ch.write_queue_len > high_wm_ff) begin
                  drain_v = 1'b1;
               end else if (single_chan_ff) begin
                  if (req_ch.read_queue_len == '0 && wait_v != dfws_pkg::WAIT_MAX) begin
                     wait_v = wait_v + dfws_pkg::WAIT_W'(1);
                  end
                  if (wait_v > wait_limit_ff) begin
                     wait_v  = '0;
                     drain_v = 1'b1;
                  end
                  write_wait_in = wait_v;
               end else begin
                  drain_v = 1'b1;
               end
               drain_mode_in  = drain_v;
               entry_count_in = '0;
               have_choice_in = 1'b0;
               have_hit_in    = 1'b0;
               choice_in      = '0;
            end
            dfws_pkg::OP_ENTRY: begin
               // Only entries of the served queue count.
               if (req_ch.entry_is_write == drain_mode_ff) begin
                  if (entry_count_ff != dfws_pkg::POS_MAX) begin
                     entry_count_in = entry_count_ff + dfws_pkg::POS_W'(1);
                  end
                  if (!have_hit_ff && req_ch.entry_issuable &&
                      !(have_choice_ff && req_ch.entry_next_cmd != dfws_pkg::CMD_COLUMN)) begin
                     if (have_choice_ff) begin
                        hit_count_in = dfws_pkg::sat_inc(hit_count_ff);
                     end
                     if (req_ch.entry_next_cmd == dfws_pkg::CMD_COLUMN) begin
                        have_hit_in = 1'b1;
                     end
                     have_choice_in = 1'b1;
                     choice_in.pos  = entry_count_ff;
                     choice_in.cmd  = req_ch.entry_next_cmd;
                     choice_in.rank = req_ch.entry_rank;
                     choice_in.bank = req_ch.entry_bank;
                  end
               end
            end
            dfws_pkg::OP_END: begin
               result_in.in_write_drain = drain_mode_ff;
               if (have_choice_ff) begin
                  // Issue the chosen request and track its bank.
                  result_in.issued_kind      = dfws_pkg::KIND_REQUEST;
                  result_in.from_write_queue = drain_mode_ff;
                  result_in.chosen_entry     = choice_ff.pos;
                  result_in.chosen_cmd       = choice_ff.cmd;
                  result_in.target_rank      = choice_ff.rank;
                  result_in.target_bank      = choice_ff.bank;
                  if (in_range_v) begin
                     if (choice_ff.cmd == dfws_pkg::CMD_COLUMN) begin
                        recent_in[choice_idx_v] = 1'b1;
                     end else if (choice_ff.cmd == dfws_pkg::CMD_ACTIVATE ||
                                  choice_ff.cmd == dfws_pkg::CMD_PRECHARGE) begin
                        recent_in[choice_idx_v] = 1'b0;
                     end
                  end
                  if (!drain_mode_ff) begin
                     if (write_wait_ff != '0) begin
                        read_wait_count_in = dfws_pkg::sat_inc(read_wait_count_ff);
                     end
                     write_wait_in = '0;
                  end
               end else if (!drain_mode_ff) begin
                  // Close the first recently used bank that may be precharged.
                  for (int i = 0; i < dfws_pkg::MASK_W; i++) begin
                     if (!found_v && RecentMask[i] && recent_ff[i] &&
                         req_ch.precharge_allowed[i]) begin
                        found_v     = 1'b1;
                        found_idx_v = 4'(i);
                     end
                  end
                  if (found_v) begin
                     result_in.issued_kind = dfws_pkg::KIND_PRECHARGE;
                     result_in.chosen_cmd  = dfws_pkg::CMD_PRECHARGE;
                     result_in.target_rank = found_idx_v[3];
                     result_in.target_bank = found_idx_v[2:0];
                     recent_in[found_idx_v] = 1'b0;
                     pre_count_in = dfws_pkg::sat_inc(pre_count_ff);
                  end
               end
               result_in.row_hit_count         = hit_count_ff;
               result_in.precharge_count       = pre_count_in;
               result_in.read_while_wait_count = read_wait_count_in;
               entry_count_in = '0;
               have_choice_in = 1'b0;
               have_hit_in    = 1'b0;
               choice_in      = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         high_wm_ff     <= dfws_pkg::HIGH_WM_RESET;
         low_wm_ff      <= dfws_pkg::LOW_WM_RESET;
         wait_limit_ff  <= dfws_pkg::WAIT_LIMIT_RESET;
         single_chan_ff <= dfws_pkg::SINGLE_CHAN_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            dfws_pkg::CSR_HIGH_WM:     high_wm_ff     <= csr_ch.data;
            dfws_pkg::CSR_LOW_WM:      low_wm_ff      <= csr_ch.data;
            dfws_pkg::CSR_WAIT_LIMIT:  wait_limit_ff  <= csr_ch.data[dfws_pkg::WAIT_W-1:0];
            dfws_pkg::CSR_SINGLE_CHAN: single_chan_ff <= csr_ch.data[0];
            default: begin
            end
         endcase
      end
   end

   // Scheduler state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         drain_mode_ff      <= 1'b0;
         write_wait_ff      <= '0;
         recent_ff          <= '0;
         entry_count_ff     <= '0;
         have_choice_ff     <= 1'b0;
         have_hit_ff        <= 1'b0;
         choice_ff          <= '0;
         hit_count_ff       <= '0;
         pre_count_ff       <= '0;
         read_wait_count_ff <= '0;
      end else begin
         drain_mode_ff      <= drain_mode_in;
         write_wait_ff      <= write_wait_in;
         recent_ff          <= recent_in & RecentMask;
         entry_count_ff     <= entry_count_in;
         have_choice_ff     <= have_choice_in;
         have_hit_ff        <= have_hit_in;
         choice_ff          <= choice_in;
         hit_count_ff       <= hit_count_in;
         pre_count_ff       <= pre_count_in;
         read_wait_count_ff <= read_wait_count_in;
      end
   end

   // Output register: holds a result item until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         rsp_valid_ff <= end_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (end_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_ch.valid                 = rsp_valid_ff;
   assign rsp_ch.issued_kind           = result_ff.issued_kind;
   assign rsp_ch.from_write_queue      = result_ff.from_write_queue;
   assign rsp_ch.chosen_entry          = result_ff.chosen_entry;
   assign rsp_ch.chosen_cmd            = result_ff.chosen_cmd;
   assign rsp_ch.target_rank           = result_ff.target_rank;
   assign rsp_ch.target_bank           = result_ff.target_bank;
   assign rsp_ch.in_write_drain        = result_ff.in_write_drain;
   assign rsp_ch.row_hit_count         = result_ff.row_hit_count;
   assign rsp_ch.precharge_count       = result_ff.precharge_count;
   assign rsp_ch.read_while_wait_count = result_ff.read_while_wait_count;

   // A column hit is only ever recorded on top of a choice.
   `DFWS_ASSERT_SAME(a_hit_has_choice, clock, reset, have_hit_ff, have_choice_ff)
   // An accepted end item always yields a result in the next cycle.
   `DFWS_ASSERT_NEXT(a_end_gives_result, clock, reset, end_accept, rsp_valid_ff)
   // An accepted end item leaves the scan state cleared.
   `DFWS_ASSERT_NEXT(a_end_clears_scan, clock, reset, end_accept,
                     !have_choice_ff && entry_count_ff == '0)
   // No aggressive precharge is reported during write drain.
   `DFWS_ASSERT_SAME(a_no_drain_precharge, clock, reset,
                     rsp_valid_ff && result_ff.issued_kind == dfws_pkg::KIND_PRECHARGE,
                     !result_ff.in_write_drain)
   // Nothing issued means an all-zero choice.
   `DFWS_ASSERT_SAME(a_idle_result_zero, clock, reset,
                     rsp_valid_ff && result_ff.issued_kind == dfws_pkg::KIND_NONE,
                     result_ff.chosen_entry == '0 && result_ff.chosen_cmd == '0 &&
                     result_ff.target_bank == '0 && result_ff.target_rank == '0)

endmodule
